// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the lexer RTL
// Clocked concurrent checks with asynchronous active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next cycle, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/bstl_pkg.sv -----
// ---------------------------------------------------------------------------
// Byte stream token lexer package
// Scanner modes, token kinds, result record and sizing constants.
// ---------------------------------------------------------------------------
package bstl_pkg;

	// Width of the length field of a result
	localparam int LEN_W = 16;

	// Default width of the open token byte counter
	localparam int LENGTH_BITS_DEF = 16;

	// Default depth of the result queue (two results per byte at most)
	localparam int RES_DEPTH_DEF = 4;

	// Scanner modes, one-hot
	typedef enum logic [12:0] {
		M_START      = 13'b0_0000_0000_0001,
		M_SPACE      = 13'b0_0000_0000_0010,
		M_TAB        = 13'b0_0000_0000_0100,
		M_CR         = 13'b0_0000_0000_1000,
		M_IDENT      = 13'b0_0000_0001_0000,
		M_INT        = 13'b0_0000_0010_0000,
		M_DEC        = 13'b0_0000_0100_0000,
		M_STR        = 13'b0_0000_1000_0000,
		M_COMMENT    = 13'b0_0001_0000_0000,
		M_COMMENT_CR = 13'b0_0010_0000_0000,
		M_UNI3       = 13'b0_0100_0000_0000,
		M_UNI2       = 13'b0_1000_0000_0000,
		M_UNI1       = 13'b1_0000_0000_0000
	} mode_t;

	// Token kinds
	typedef enum logic [4:0] {
		K_SPACE    = 5'd0,
		K_TAB      = 5'd1,
		K_LF       = 5'd2,
		K_CR       = 5'd3,
		K_CRLF     = 5'd4,
		K_LPAREN   = 5'd5,
		K_RPAREN   = 5'd6,
		K_LBRACKET = 5'd7,
		K_RBRACKET = 5'd8,
		K_LBRACE   = 5'd9,
		K_RBRACE   = 5'd10,
		K_SLASH    = 5'd11,
		K_INT      = 5'd12,
		K_DEC      = 5'd13,
		K_STR      = 5'd14,
		K_COMMENT  = 5'd15,
		K_IDENT    = 5'd16,
		K_UNKNOWN  = 5'd17,
		K_EOF      = 5'd18
	} kind_t;

	// One token result
	typedef struct packed {
		kind_t            kind;
		logic [LEN_W-1:0] length;
		logic             last;
	} res_t;

	// Results caused by one byte: count (0..2) and the two slots in order
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} lex_out_t;

endpackage

// ----- sv/bstl_byte_if.sv -----
// ---------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one source byte per transfer.
// ---------------------------------------------------------------------------
interface bstl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_req;

	modport source (output valid, output byte_req, input ready);
	modport sink (input valid, input byte_req, output ready);
endinterface

// ----- sv/bstl_tok_if.sv -----
// ---------------------------------------------------------------------------
// Token result channel
// Valid/ready channel carrying one token (kind, length, last) per transfer.
// ---------------------------------------------------------------------------
interface bstl_tok_if;
	logic                       valid;
	logic                       ready;
	logic [4:0]                 kind;
	logic [bstl_pkg::LEN_W-1:0] length;
	logic                       last;

	modport source (output valid, output kind, output length, output last, input ready);
	modport sink (input valid, input kind, input length, input last, output ready);
endinterface

// ----- sv/bstl_lex_step.sv -----
// ---------------------------------------------------------------------------
// Lexer step logic
// Next mode, next byte count and up to two token results for one byte.
// ---------------------------------------------------------------------------
module bstl_lex_step #(
	parameter int LENGTH_BITS = bstl_pkg::LENGTH_BITS_DEF
) (
	input  logic [7:0]             byte_req,
	input  bstl_pkg::mode_t        mode,
	input  logic [LENGTH_BITS-1:0] count,
	output bstl_pkg::mode_t        mode_nxt,
	output logic [LENGTH_BITS-1:0] count_nxt,
	output bstl_pkg::lex_out_t     lex
);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRKT  = 8'h5B;
	localparam logic [7:0] CH_RBRKT  = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] UTF2_LO   = 8'b1100_0000;
	localparam logic [7:0] UTF2_HI   = 8'b1101_1111;
	localparam logic [7:0] UTF3_LO   = 8'b1110_0000;
	localparam logic [7:0] UTF3_HI   = 8'b1110_1111;
	localparam logic [7:0] UTF4_LO   = 8'b1111_0000;
	localparam logic [7:0] UTF4_HI   = 8'b1111_0111;
	localparam int LenW = bstl_pkg::LEN_W;

	function automatic logic is_delim(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF) ||
			(b == CH_NUL) || (b == CH_SEMI) || (b == CH_SLASH) ||
			(b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRKT) ||
			(b == CH_RBRKT) || (b == CH_LBRACE) || (b == CH_RBRACE);
	endfunction

	function automatic logic is_numeral(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	// Letters, '_', '-' and the identifier punctuation set
	function automatic logic is_ident_start(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			(b == 8'h21) || (b == 8'h23) || (b == 8'h24) || (b == 8'h25) ||
			(b == 8'h26) || (b == 8'h27) || (b == 8'h2A) || (b == 8'h2B) ||
			(b == 8'h2C) || (b == 8'h2D) || (b == 8'h2E) || (b == 8'h3A) ||
			(b == 8'h3C) || (b == 8'h3D) || (b == 8'h3E) || (b == 8'h3F) ||
			(b == 8'h40) || (b == 8'h5C) || (b == 8'h5E) || (b == 8'h5F) ||
			(b == 8'h60) || (b == 8'h7C);
	endfunction

	// Lexing from start
	bstl_pkg::mode_t        fs_mode;
	logic                   fs_emit;
	bstl_pkg::kind_t        fs_kind;
	logic [LenW-1:0]        fs_len;

	// Open token handling
	logic [LENGTH_BITS-1:0] cnt_inc;
	logic                   do_fs;
	logic                   have0;
	bstl_pkg::kind_t        k0;
	logic [LENGTH_BITS-1:0] len0_src;
	logic [LENGTH_BITS+LenW-1:0] len0_ext;
	logic [LenW-1:0]        len0;

	// Saturating bump of the open token count
	assign cnt_inc = (&count) ? count : count + 1'b1;

	// Single byte lexed from the start mode
	always_comb begin
		fs_mode = bstl_pkg::M_START;
		fs_emit = 1'b0;
		fs_kind = bstl_pkg::K_UNKNOWN;
		fs_len  = '0;
		unique case (byte_req)
			CH_NUL: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_EOF;
			end
			CH_TAB:    fs_mode = bstl_pkg::M_TAB;
			CH_LF: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_LF;
			end
			CH_CR:     fs_mode = bstl_pkg::M_CR;
			CH_SPACE:  fs_mode = bstl_pkg::M_SPACE;
			CH_QUOTE:  fs_mode = bstl_pkg::M_STR;
			CH_SEMI:   fs_mode = bstl_pkg::M_COMMENT;
			CH_LPAREN: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_LPAREN;
			end
			CH_RPAREN: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_RPAREN;
			end
			CH_LBRKT: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_LBRACKET;
			end
			CH_RBRKT: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_RBRACKET;
			end
			CH_LBRACE: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_LBRACE;
			end
			CH_RBRACE: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_RBRACE;
			end
			CH_SLASH: begin
				fs_emit = 1'b1;
				fs_kind = bstl_pkg::K_SLASH;
			end
			default: begin
				if (is_numeral(byte_req)) begin
					fs_mode = bstl_pkg::M_INT;
				end else if ((byte_req >= UTF2_LO) && (byte_req <= UTF2_HI)) begin
					fs_mode = bstl_pkg::M_UNI1;
				end else if ((byte_req >= UTF3_LO) && (byte_req <= UTF3_HI)) begin
					fs_mode = bstl_pkg::M_UNI2;
				end else if ((byte_req >= UTF4_LO) && (byte_req <= UTF4_HI)) begin
					fs_mode = bstl_pkg::M_UNI3;
				end else if (is_ident_start(byte_req)) begin
					fs_mode = bstl_pkg::M_IDENT;
				end else begin
					fs_emit = 1'b1;
					fs_kind = bstl_pkg::K_UNKNOWN;
					fs_len  = LenW'(1);
				end
			end
		endcase
	end

	// Mode update; first result is a closed or finished token
	always_comb begin
		do_fs     = 1'b0;
		have0     = 1'b0;
		k0        = bstl_pkg::K_SPACE;
		len0_src  = count;
		mode_nxt  = mode;
		count_nxt = cnt_inc;
		unique case (mode)
			bstl_pkg::M_SPACE: begin
				if (byte_req != CH_SPACE) begin
					have0 = 1'b1;
					k0    = bstl_pkg::K_SPACE;
					do_fs = 1'b1;
				end
			end
			bstl_pkg::M_TAB: begin
				if (byte_req != CH_TAB) begin
					have0 = 1'b1;
					k0    = bstl_pkg::K_TAB;
					do_fs = 1'b1;
				end
			end
			bstl_pkg::M_CR: begin
				have0    = 1'b1;
				len0_src = '0;
				if (byte_req == CH_LF) begin
					k0        = bstl_pkg::K_CRLF;
					mode_nxt  = bstl_pkg::M_START;
					count_nxt = '0;
				end else begin
					k0    = bstl_pkg::K_CR;
					do_fs = 1'b1;
				end
			end
			bstl_pkg::M_INT: begin
				if (byte_req == CH_DOT) begin
					mode_nxt = bstl_pkg::M_DEC;
				end else if (is_delim(byte_req)) begin
					have0 = 1'b1;
					k0    = bstl_pkg::K_INT;
					do_fs = 1'b1;
				end else if (!is_numeral(byte_req)) begin
					mode_nxt = bstl_pkg::M_IDENT;
				end
			end
			bstl_pkg::M_DEC: begin
				if (is_delim(byte_req)) begin
					have0 = 1'b1;
					k0    = bstl_pkg::K_DEC;
					do_fs = 1'b1;
				end else if (!is_numeral(byte_req)) begin
					mode_nxt = bstl_pkg::M_IDENT;
				end
			end
			bstl_pkg::M_STR: begin
				if (byte_req == CH_QUOTE) begin
					have0     = 1'b1;
					k0        = bstl_pkg::K_STR;
					len0_src  = cnt_inc;
					mode_nxt  = bstl_pkg::M_START;
					count_nxt = '0;
				end
			end
			bstl_pkg::M_COMMENT: begin
				if (byte_req == CH_LF) begin
					have0     = 1'b1;
					k0        = bstl_pkg::K_COMMENT;
					len0_src  = cnt_inc;
					mode_nxt  = bstl_pkg::M_START;
					count_nxt = '0;
				end else if (byte_req == CH_CR) begin
					mode_nxt = bstl_pkg::M_COMMENT_CR;
				end
			end
			bstl_pkg::M_COMMENT_CR: begin
				have0 = 1'b1;
				k0    = bstl_pkg::K_COMMENT;
				if (byte_req == CH_LF) begin
					len0_src  = cnt_inc;
					mode_nxt  = bstl_pkg::M_START;
					count_nxt = '0;
				end else begin
					do_fs = 1'b1;
				end
			end
			bstl_pkg::M_UNI3: mode_nxt = bstl_pkg::M_UNI2;
			bstl_pkg::M_UNI2: mode_nxt = bstl_pkg::M_UNI1;
			bstl_pkg::M_UNI1: mode_nxt = bstl_pkg::M_IDENT;
			bstl_pkg::M_IDENT: begin
				if (is_delim(byte_req)) begin
					have0 = 1'b1;
					k0    = bstl_pkg::K_IDENT;
					do_fs = 1'b1;
				end
			end
			default: do_fs = 1'b1;
		endcase
		// Byte that closed a token (or arrived at start) is lexed from start
		if (do_fs) begin
			mode_nxt  = fs_mode;
			count_nxt = (fs_mode == bstl_pkg::M_START) ? '0 : LENGTH_BITS'(1);
		end
	end

	// Clip the reported length to the length field
	assign len0_ext = {{LenW{1'b0}}, len0_src};
	assign len0     = (|len0_ext[LENGTH_BITS+LenW-1:LenW]) ? '1 : len0_ext[LenW-1:0];

	// Pack results in order; the final one carries last
	always_comb begin
		lex.n         = 2'd0;
		lex.r0.kind   = k0;
		lex.r0.length = len0;
		lex.r0.last   = 1'b1;
		lex.r1.kind   = fs_kind;
		lex.r1.length = fs_len;
		lex.r1.last   = 1'b1;
		if (have0) begin
			if (do_fs && fs_emit) begin
				lex.n       = 2'd2;
				lex.r0.last = 1'b0;
			end else begin
				lex.n = 2'd1;
			end
		end else if (do_fs && fs_emit) begin
			lex.n         = 2'd1;
			lex.r0.kind   = fs_kind;
			lex.r0.length = fs_len;
		end
	end

endmodule

// ----- sv/bstl_res_fifo.sv -----
// ---------------------------------------------------------------------------
// Token result queue
// Takes up to two results per cycle, hands out one per output transfer.
// ---------------------------------------------------------------------------
module bstl_res_fifo #(
	parameter int RES_DEPTH = bstl_pkg::RES_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       push_n,
	input  bstl_pkg::res_t                   d0,
	input  bstl_pkg::res_t                   d1,
	output logic [$clog2(RES_DEPTH+1)-1:0]   free,
	bstl_tok_if.source                       tokens
);

	localparam int PtrW = $clog2(RES_DEPTH);
	localparam int CntW = $clog2(RES_DEPTH + 1);

	bstl_pkg::res_t  mem_q [RES_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic [PtrW-1:0] wr_ptr1;
	logic [PtrW-1:0] wr_ptr2;
	logic [PtrW-1:0] rd_ptr_inc;
	logic            pop;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		return (p == PtrW'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr1    = ptr_next(wr_ptr_q);
	assign wr_ptr2    = ptr_next(wr_ptr1);
	assign rd_ptr_inc = ptr_next(rd_ptr_q);
	assign pop        = tokens.valid && tokens.ready;
	assign free       = CntW'(RES_DEPTH) - cnt_q;

	// Head of queue drives the channel
	assign tokens.valid  = (cnt_q != '0);
	assign tokens.kind   = mem_q[rd_ptr_q].kind;
	assign tokens.length = mem_q[rd_ptr_q].length;
	assign tokens.last   = mem_q[rd_ptr_q].last;

	// Storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr1] <= d1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_ptr1;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= wr_ptr2;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			cnt_q <= cnt_q + CntW'(push_n) - CntW'(pop);
		end
	end

endmodule

// ----- sv/byte_stream_token_lexer_core.sv -----
// ---------------------------------------------------------------------------
// Byte stream token lexer
// Lexes one source byte per transfer into kind/length tokens.
//
//   channel  | dir | payload                      | per transfer
//   ---------+-----+------------------------------+---------------------------
//   bytes    | in  | byte_req[7:0]                | one source byte
//   tokens   | out | kind[4:0] length[15:0] last  | one token, last marks byte end
//
// A byte is registered at its input transfer and lexed in the next cycle; its
// zero, one or two tokens enter the result queue once they fit there.
// One byte per cycle is taken while the queue has room for the registered
// byte's results; the queue drains one token per cycle, so only a stalled token
// channel or a run of two-token bytes that fills the queue holds the input.
// Reset: start mode, no token open, queue empty; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_stream_token_lexer_core #(
	parameter int LENGTH_BITS = bstl_pkg::LENGTH_BITS_DEF,
	parameter int RES_DEPTH   = bstl_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bstl_byte_if.sink   bytes,
	bstl_tok_if.source  tokens
);

	localparam int CntW = $clog2(RES_DEPTH + 1);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	bstl_pkg::mode_t        mode_q;
	logic [LENGTH_BITS-1:0] count_q;
	bstl_pkg::mode_t        mode_nxt;
	logic [LENGTH_BITS-1:0] count_nxt;
	bstl_pkg::lex_out_t     lex;
	logic [CntW-1:0]        free;
	logic                   adv;
	logic [1:0]             push_n;
	logic                   s1_stall;
	logic                   pair_ok;
	logic                   eof_out;
	logic                   at_start;

	// Registered byte retires once its results fit in the queue
	assign adv          = valid_s1 && (free >= CntW'(lex.n));
	assign push_n       = adv ? lex.n : 2'd0;
	assign bytes.ready  = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_req;
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bstl_pkg::M_START;
			count_q <= '0;
		end else if (adv) begin
			mode_q  <= mode_nxt;
			count_q <= count_nxt;
		end
	end

	bstl_lex_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.byte_req  (byte_s1),
		.mode      (mode_q),
		.count     (count_q),
		.mode_nxt  (mode_nxt),
		.count_nxt (count_nxt),
		.lex       (lex)
	);

	bstl_res_fifo #(
		.RES_DEPTH (RES_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (lex.r0),
		.d1     (lex.r1),
		.free   (free),
		.tokens (tokens)
	);

	// Check terms; the step outputs only count while a byte is registered
	assign s1_stall = valid_s1 && !adv;
	assign pair_ok  = !valid_s1 || (lex.n != 2'd2) || (!lex.r0.last && lex.r1.last);
	assign eof_out  = ((lex.n == 2'd1) && (lex.r0.kind == bstl_pkg::K_EOF)) ||
		((lex.n == 2'd2) && (lex.r1.kind == bstl_pkg::K_EOF));
	assign at_start = (mode_q == bstl_pkg::M_START) && (count_q == '0);

	// Checks
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_stall, valid_s1 && $stable(byte_s1), "stalled byte lost")
	`ASSERT_CLK(a_pair_order, clk, arst_n, pair_ok, "two-result byte misordered")
	`ASSERT_NEXT(a_eof_start, clk, arst_n, adv && eof_out, at_start, "eof did not return to start")
	`ASSERT_CLK(a_fifo_bound, clk, arst_n, free <= CntW'(RES_DEPTH), "result queue overfilled")

endmodule

// ----- bench/byte_stream_token_lexer_core_tb.sv -----
// ---------------------------------------------------------------------------
// Byte stream token lexer testbench
// Feeds source bytes through the byte channel and checks every token on the
// token channel against an in-bench lexer that tracks the same scan state.
// A directed opening covers many token rules, then a long string is sent back
// to back. A back-pressure burst follows, then randomized token text is sent
// with random gaps on both channels and a drain pause halfway through.
// ---------------------------------------------------------------------------
module byte_stream_token_lexer_core_tb;

	localparam int LENGTH_BITS = bstl_pkg::LENGTH_BITS_DEF;
	localparam int RANDOM_BYTES = 440;
	localparam int LONG_BODY = 40;

	// Byte values with special meaning to the lexer
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_GRAVE = 8'h60;

	// Tracks the scan state and holds the tokens still owed by the block
	class lexer_token_ledger;
		bstl_pkg::mode_t mode;
		longint unsigned open_len;
		longint unsigned len_cap;
		bstl_pkg::res_t  pending_tokens[$];
		bstl_pkg::res_t  batch[$];
		int unsigned     mismatches;
		int unsigned     tokens_checked;
		bit [18:0]       kinds_seen;

		function new(int unsigned len_bits);
			len_cap = (len_bits >= 64) ? '1 : ((64'd1 << len_bits) - 1);
			mode = bstl_pkg::M_START;
			open_len = 0;
		endfunction

		static function bit is_numeral(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		static function bit is_delim(logic [7:0] b);
			case (b)
				CH_SP, CH_TAB, CH_CR, CH_LF, CH_NUL, CH_SEMI, "/",
				"(", ")", "[", "]", "{", "}": return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		static function bit is_ident_start(logic [7:0] b);
			if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
				return 1'b1;
			case (b)
				"!", "#", "$", "%", "&", "'", "*", "+", ",", "-", ".", ":",
				"<", "=", ">", "?", "@", "\\", "^", "_", CH_GRAVE, "|": return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void count_byte();
			if (open_len < len_cap)
				open_len++;
		endfunction

		function void add_token(bstl_pkg::kind_t k, longint unsigned n);
			bstl_pkg::res_t r;
			r.kind = k;
			r.length = (n > 64'hFFFF) ? 16'hFFFF : n[bstl_pkg::LEN_W-1:0];
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		// Scan a byte as the first byte of a new token
		function void lex_fresh(logic [7:0] b);
			mode = bstl_pkg::M_START;
			open_len = 1;
			case (b)
				CH_NUL:   add_token(bstl_pkg::K_EOF, 0);
				CH_TAB:   mode = bstl_pkg::M_TAB;
				CH_LF:    add_token(bstl_pkg::K_LF, 0);
				CH_CR:    mode = bstl_pkg::M_CR;
				CH_SP:    mode = bstl_pkg::M_SPACE;
				CH_QUOTE: mode = bstl_pkg::M_STR;
				CH_SEMI:  mode = bstl_pkg::M_COMMENT;
				"(":      add_token(bstl_pkg::K_LPAREN, 0);
				")":      add_token(bstl_pkg::K_RPAREN, 0);
				"[":      add_token(bstl_pkg::K_LBRACKET, 0);
				"]":      add_token(bstl_pkg::K_RBRACKET, 0);
				"{":      add_token(bstl_pkg::K_LBRACE, 0);
				"}":      add_token(bstl_pkg::K_RBRACE, 0);
				"/":      add_token(bstl_pkg::K_SLASH, 0);
				default: begin
					if (is_numeral(b))
						mode = bstl_pkg::M_INT;
					else if (b >= 8'hC0 && b <= 8'hDF)
						mode = bstl_pkg::M_UNI1;
					else if (b >= 8'hE0 && b <= 8'hEF)
						mode = bstl_pkg::M_UNI2;
					else if (b >= 8'hF0 && b <= 8'hF7)
						mode = bstl_pkg::M_UNI3;
					else if (is_ident_start(b))
						mode = bstl_pkg::M_IDENT;
					else
						add_token(bstl_pkg::K_UNKNOWN, 1);
				end
			endcase
			if (mode == bstl_pkg::M_START)
				open_len = 0;
		endfunction

		// Byte ends the open token without belonging to it
		function void close_and_restart(bstl_pkg::kind_t k, logic [7:0] b);
			add_token(k, open_len);
			lex_fresh(b);
		endfunction

		// Byte is the final byte of the open token
		function void close_with(bstl_pkg::kind_t k);
			count_byte();
			add_token(k, open_len);
			mode = bstl_pkg::M_START;
			open_len = 0;
		endfunction

		// Accepted source byte: advance the scan and queue its tokens
		function void note_byte(logic [7:0] b);
			batch.delete();
			case (mode)
				bstl_pkg::M_SPACE: begin
					if (b == CH_SP) count_byte();
					else close_and_restart(bstl_pkg::K_SPACE, b);
				end
				bstl_pkg::M_TAB: begin
					if (b == CH_TAB) count_byte();
					else close_and_restart(bstl_pkg::K_TAB, b);
				end
				bstl_pkg::M_CR: begin
					if (b == CH_LF) begin
						add_token(bstl_pkg::K_CRLF, 0);
						mode = bstl_pkg::M_START;
						open_len = 0;
					end else begin
						add_token(bstl_pkg::K_CR, 0);
						lex_fresh(b);
					end
				end
				bstl_pkg::M_INT: begin
					if (b == CH_DOT) begin
						count_byte();
						mode = bstl_pkg::M_DEC;
					end else if (is_delim(b)) begin
						close_and_restart(bstl_pkg::K_INT, b);
					end else begin
						count_byte();
						if (!is_numeral(b))
							mode = bstl_pkg::M_IDENT;
					end
				end
				bstl_pkg::M_DEC: begin
					if (is_delim(b)) begin
						close_and_restart(bstl_pkg::K_DEC, b);
					end else begin
						count_byte();
						if (!is_numeral(b))
							mode = bstl_pkg::M_IDENT;
					end
				end
				bstl_pkg::M_STR: begin
					if (b == CH_QUOTE) close_with(bstl_pkg::K_STR);
					else count_byte();
				end
				bstl_pkg::M_COMMENT: begin
					if (b == CH_LF) begin
						close_with(bstl_pkg::K_COMMENT);
					end else begin
						count_byte();
						if (b == CH_CR)
							mode = bstl_pkg::M_COMMENT_CR;
					end
				end
				bstl_pkg::M_COMMENT_CR: begin
					if (b == CH_LF) close_with(bstl_pkg::K_COMMENT);
					else close_and_restart(bstl_pkg::K_COMMENT, b);
				end
				bstl_pkg::M_UNI3: begin
					count_byte();
					mode = bstl_pkg::M_UNI2;
				end
				bstl_pkg::M_UNI2: begin
					count_byte();
					mode = bstl_pkg::M_UNI1;
				end
				bstl_pkg::M_UNI1: begin
					count_byte();
					mode = bstl_pkg::M_IDENT;
				end
				bstl_pkg::M_IDENT: begin
					if (is_delim(b)) close_and_restart(bstl_pkg::K_IDENT, b);
					else count_byte();
				end
				default: lex_fresh(b);
			endcase
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				pending_tokens.push_back(batch[i]);
		endfunction

		// Accepted token: compare with the oldest owed token
		function void check(logic [4:0] k, logic [bstl_pkg::LEN_W-1:0] len, logic lst);
			bstl_pkg::res_t want;
			if (k < 19)
				kinds_seen[k] = 1'b1;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d len %0d last %0b", k, len, lst);
				return;
			end
			want = pending_tokens.pop_front();
			tokens_checked++;
			if (k !== want.kind || len !== want.length || lst !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("token %0d: got kind %0d len %0d last %0b, want kind %0d len %0d last %0b",
						tokens_checked, k, len, lst, want.kind, want.length, want.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bstl_byte_if byte_ch();
	bstl_tok_if  tok_ch();

	lexer_token_ledger ledger = new(LENGTH_BITS);

	bit          src_idle;
	bit          sink_idle;
	bit          hold_req;
	int          hold_len;
	int unsigned bytes_sent;
	string       ident_punct = "!#$%&'*+,-.:<=>?@\\^_|";

	byte_stream_token_lexer_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_ch),
		.tokens(tok_ch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	// Transfer monitor: bytes are noted before tokens are checked
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
				ledger.note_byte(byte_ch.byte_req);
			if (tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1)
				ledger.check(tok_ch.kind, tok_ch.length, tok_ch.last);
		end
	end

	// Token sink: random stalls, plus a long hold-off on request
	initial begin : token_sink
		int stall;
		tok_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				tok_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = sink_idle ? $urandom_range(0, 5) : 0;
			repeat (stall) begin
				tok_ch.ready <= 1'b0;
				@(posedge clk);
			end
			tok_ch.ready <= 1'b1;
			do @(posedge clk); while (tok_ch.valid !== 1'b1 && !hold_req);
		end
	end

	// Offer one byte, after a random gap while src_idle is set, and wait for its transfer
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		repeat (gap) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_req <= b;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		bytes_sent++;
	endtask

	task automatic send_text(input logic [7:0] txt[$]);
		foreach (txt[i])
			send_byte(txt[i]);
	endtask

	// Stop offering and wait until every owed token has been seen
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		do @(negedge clk); while (ledger.pending_tokens.size() != 0);
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_ident_char();
		case ($urandom_range(0, 3))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return ident_punct[$urandom_range(0, ident_punct.len() - 1)];
			default: return $urandom_range(0, 7) ? 8'("a" + $urandom_range(0, 25)) : CH_GRAVE;
		endcase
	endfunction

	// Bytes that start no token and form a one-byte unknown
	function automatic logic [7:0] rand_unknown();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(8'h01, 8'h08));
			1: return 8'($urandom_range(8'h0B, 8'h0C));
			2: return 8'($urandom_range(8'h0E, 8'h1F));
			3: return 8'($urandom_range(8'h7F, 8'hBF));
			default: return 8'($urandom_range(8'hF8, 8'hFF));
		endcase
	endfunction

	// Build the text of one random token, mostly well formed
	function automatic void pick_token(ref logic [7:0] txt[$]);
		int n;
		logic [7:0] c;
		txt.delete();
		case ($urandom_range(0, 15))
			0: begin
				c = $urandom_range(0, 1) ? CH_SP : CH_TAB;
				repeat ($urandom_range(1, 4)) txt.push_back(c);
			end
			1: begin
				case ($urandom_range(0, 2))
					0: txt.push_back(CH_LF);
					1: txt.push_back(CH_CR);
					default: begin
						txt.push_back(CH_CR);
						txt.push_back(CH_LF);
					end
				endcase
			end
			2: begin
				case ($urandom_range(0, 6))
					0: txt.push_back("(");
					1: txt.push_back(")");
					2: txt.push_back("[");
					3: txt.push_back("]");
					4: txt.push_back("{");
					5: txt.push_back("}");
					default: txt.push_back("/");
				endcase
			end
			3: repeat ($urandom_range(1, 4)) txt.push_back(rand_digit());
			4: begin
				repeat ($urandom_range(1, 3)) txt.push_back(rand_digit());
				txt.push_back(CH_DOT);
				repeat ($urandom_range(0, 3)) txt.push_back(rand_digit());
			end
			5: begin
				txt.push_back(rand_ident_char());
				repeat ($urandom_range(0, 5))
					txt.push_back($urandom_range(0, 3) ? rand_ident_char() : rand_digit());
			end
			6: begin
				// number that turns into an identifier
				repeat ($urandom_range(1, 3)) txt.push_back(rand_digit());
				if ($urandom_range(0, 1))
					txt.push_back(CH_DOT);
				repeat ($urandom_range(1, 3)) txt.push_back(rand_ident_char());
			end
			7: begin
				txt.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 5)) begin
					c = 8'($urandom_range(0, 255));
					txt.push_back(c == CH_QUOTE ? CH_NUL : c);
				end
				txt.push_back(CH_QUOTE);
			end
			8: begin
				txt.push_back(CH_SEMI);
				repeat ($urandom_range(0, 5)) begin
					c = 8'($urandom_range(0, 255));
					txt.push_back((c == CH_CR || c == CH_LF) ? CH_NUL : c);
				end
				case ($urandom_range(0, 2))
					0: txt.push_back(CH_LF);
					1: txt.push_back(CH_CR);
					default: begin
						txt.push_back(CH_CR);
						txt.push_back(CH_LF);
					end
				endcase
			end
			9: begin
				// UTF-8 lead byte, swallowed bytes, then identifier tail
				case ($urandom_range(0, 2))
					0: begin
						txt.push_back(8'($urandom_range(8'hC0, 8'hDF)));
						n = 1;
					end
					1: begin
						txt.push_back(8'($urandom_range(8'hE0, 8'hEF)));
						n = 2;
					end
					default: begin
						txt.push_back(8'($urandom_range(8'hF0, 8'hF7)));
						n = 3;
					end
				endcase
				repeat (n)
					txt.push_back($urandom_range(0, 2) ? 8'($urandom_range(8'h80, 8'hBF))
						: 8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 2)) txt.push_back(rand_ident_char());
			end
			10: txt.push_back(rand_unknown());
			11: txt.push_back(CH_NUL);
			12, 13: txt.push_back(CH_SP);
			14: begin
				// unterminated string or comment, closed later if at all
				txt.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_SEMI);
				repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
			end
			default: repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
		endcase
	endfunction

	// Main sequence
	initial begin
		logic [7:0] txt[$];
		logic [7:0] c;
		int unsigned random_sent;
		int unsigned next_phase;
		bit paused;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_req = 8'h00;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		hold_req = 1'b0;
		hold_len = 0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: eof at start, runs, newlines, brackets, numbers, comment,
		// NUL inside a string and a UTF-8 sequence, NUL ending a token
		txt = '{CH_NUL, CH_SP, CH_SP, CH_TAB, CH_LF, CH_CR, "A", "(", ")", "[", "]",
			"{", "}", "/", "4", ".", "5", CH_SP, "8", "z", CH_SEMI, CH_CR, CH_LF,
			CH_QUOTE, CH_NUL, CH_QUOTE, 8'hF7, CH_NUL, 8'h80, CH_CR, "!", 8'hFF, CH_NUL};
		send_text(txt);

		// Long string sent back to back
		src_idle = 1'b0;
		send_byte(CH_QUOTE);
		repeat (LONG_BODY) begin
			c = 8'($urandom_range(0, 255));
			send_byte(c == CH_QUOTE ? CH_NUL : c);
		end
		send_byte(CH_QUOTE);

		// Token channel held off while bytes keep coming, two tokens per pair
		hold_len = 120;
		hold_req = 1'b1;
		repeat (20) begin
			send_byte("x");
			send_byte("(");
		end
		src_idle = 1'b1;

		// Random token text with rotating idle patterns
		random_sent = 0;
		next_phase = 0;
		paused = 1'b0;
		while (random_sent < RANDOM_BYTES) begin
			if (random_sent >= next_phase) begin
				case ($urandom_range(0, 4))
					0: {src_idle, sink_idle} = 2'b00;
					1: {src_idle, sink_idle} = 2'b01;
					2: {src_idle, sink_idle} = 2'b10;
					default: {src_idle, sink_idle} = 2'b11;
				endcase
				next_phase = random_sent + $urandom_range(30, 80);
			end
			if (!paused && random_sent >= RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			pick_token(txt);
			send_text(txt);
			random_sent += txt.size();
		end

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Lexed %0d source bytes into %0d tokens; %0d of 19 token kinds seen.",
			bytes_sent, ledger.tokens_checked, $countones(ledger.kinds_seen));
		$display("Runs included an output hold-off, a drain pause and mixed idle patterns.");
		if (ledger.pending_tokens.size() != 0)
			$display("%0d expected tokens never arrived", ledger.pending_tokens.size());
		if (ledger.mismatches == 0 && ledger.pending_tokens.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", ledger.mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bstl_pkg.sv
sv/bstl_byte_if.sv
sv/bstl_tok_if.sv
sv/bstl_lex_step.sv
sv/bstl_res_fifo.sv
sv/byte_stream_token_lexer_core.sv
bench/byte_stream_token_lexer_core_tb.sv
